>>> design/two_group_shared_access_arbiter_defines.svh
// Assertion macros used by the arbiter datapath.
`ifndef TWO_GROUP_SHARED_ACCESS_ARBITER_DEFINES_SVH
`define TWO_GROUP_SHARED_ACCESS_ARBITER_DEFINES_SVH

// Invariant that holds at every clock edge outside reset.
`define TGSA_ASSERT_NOW(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tgsa: invariant violated");

// Condition that must hold in the same cycle as the trigger.
`define TGSA_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tgsa: implication violated");

`endif

>>> design/tgsa_pkg.sv
// Constants, event codes and controller/datapath link types of the arbiter.
package tgsa_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 8;
   localparam int MAX_INSIDE  = 255;

   localparam int ID_FIELD_W = 8;
   localparam int ID_W       = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;
   localparam int CNT_W      = $clog2(MAX_INSIDE + 1);
   localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_W     = $clog2(QUEUE_DEPTH);
   localparam int EV_W       = 3;

   localparam logic MODE_ENTER = 1'b0;
   localparam logic MODE_EXIT  = 1'b1;

   localparam logic [EV_W-1:0] EV_GRANTED    = 3'd0;
   localparam logic [EV_W-1:0] EV_QUEUED     = 3'd1;
   localparam logic [EV_W-1:0] EV_RELEASED   = 3'd2;
   localparam logic [EV_W-1:0] EV_EXIT_ERROR = 3'd3;
   localparam logic [EV_W-1:0] EV_QUEUE_FULL = 3'd4;
   localparam logic [EV_W-1:0] EV_OCC_FULL   = 3'd5;

   typedef struct packed {
      logic load;    // capture the accepted request beat
      logic decide;  // commit the request and emit its first result
      logic read;    // fetch the head of the draining queue
      logic grant;   // commit one drained grant and emit it
   } tgsa_cmd_type;

   typedef struct packed {
      logic out_free;     // result register can take a beat this cycle
      logic drain_next;   // decision is followed by at least one grant
      logic grant_more;   // another grant follows the current one
   } tgsa_stat_type;

endpackage

>>> design/tgsa_dp.sv
// Datapath: occupancy counts, waiting queues and the result register.
`include "two_group_shared_access_arbiter_defines.svh"

module tgsa_dp import tgsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_mode,
   input  logic                  in_group,
   input  logic [ID_FIELD_W-1:0] in_id,
   input  tgsa_cmd_type          cmd,
   output tgsa_stat_type         stat,
   input  logic                  out_ready,
   output logic                  out_valid,
   output logic [EV_W-1:0]       out_event,
   output logic [ID_FIELD_W-1:0] out_who,
   output logic                  out_group,
   output logic                  out_last
);

   logic              mode_ff, mode_in;
   logic              grp_ff, grp_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [CNT_W-1:0]  cnt_ff [2];
   logic [CNT_W-1:0]  cnt_in [2];
   logic [FILL_W-1:0] fill_ff [2];
   logic [FILL_W-1:0] fill_in [2];
   logic [QIDX_W-1:0] head_ff [2];
   logic [QIDX_W-1:0] head_in [2];
   logic              dgrp_ff, dgrp_in;
   logic [ID_W-1:0]   rd_data_ff;
   logic [ID_W-1:0]   mem_ff [2][QUEUE_DEPTH];

   logic                  ovalid_ff, ovalid_in;
   logic [EV_W-1:0]       oev_ff, oev_in;
   logic [ID_FIELD_W-1:0] owho_ff, owho_in;
   logic                  ogrp_ff, ogrp_in;
   logic                  olast_ff, olast_in;

   logic              g, o;
   logic              other_busy, queue_full, own_at_max;
   logic [CNT_W:0]    own_cnt_inc;
   logic [FILL_W:0]   pos_sum;
   logic [QIDX_W-1:0] push_pos;
   logic              dec_push, dec_inc, dec_dec, dec_drain, dec_dgrp;
   logic [EV_W-1:0]   dec_event;
   logic [CNT_W:0]    drain_cnt_inc;
   logic              grant_more;
   logic [QIDX_W-1:0] head_step;

   assign g = grp_ff;
   assign o = ~grp_ff;

   assign other_busy  = (cnt_ff[o] != '0) || (fill_ff[o] != '0);
   assign queue_full  = (fill_ff[g] == FILL_W'(QUEUE_DEPTH));
   assign own_at_max  = (cnt_ff[g] == CNT_W'(MAX_INSIDE));
   assign own_cnt_inc = {1'b0, cnt_ff[g]} + (CNT_W+1)'(1);

   // Tail slot = head + fill, wrapped once at the queue depth.
   assign pos_sum  = (FILL_W+1)'(head_ff[g]) + (FILL_W+1)'(fill_ff[g]);
   assign push_pos = (pos_sum >= (FILL_W+1)'(QUEUE_DEPTH)) ?
                     QIDX_W'(pos_sum - (FILL_W+1)'(QUEUE_DEPTH)) : QIDX_W'(pos_sum);

   always_comb begin
      dec_push  = 1'b0;
      dec_inc   = 1'b0;
      dec_dec   = 1'b0;
      dec_drain = 1'b0;
      dec_dgrp  = g;
      dec_event = EV_GRANTED;
      if (mode_ff == MODE_ENTER) begin
         if (other_busy) begin
            if (queue_full) begin
               dec_event = EV_QUEUE_FULL;
            end else begin
               dec_event = EV_QUEUED;
               dec_push  = 1'b1;
            end
         end else if (own_at_max) begin
            dec_event = EV_OCC_FULL;
         end else begin
            dec_event = EV_GRANTED;
            dec_inc   = 1'b1;
            dec_drain = (fill_ff[g] != '0) &&
                        (own_cnt_inc != (CNT_W+1)'(MAX_INSIDE));
         end
      end else begin
         if (cnt_ff[g] == '0) begin
            dec_event = EV_EXIT_ERROR;
         end else begin
            dec_event = EV_RELEASED;
            dec_dec   = 1'b1;
            dec_dgrp  = o;
            // Last member out hands the resource to the other group.
            dec_drain = (cnt_ff[g] == CNT_W'(1)) && (fill_ff[o] != '0) &&
                        (cnt_ff[o] != CNT_W'(MAX_INSIDE));
         end
      end
   end

   assign drain_cnt_inc = {1'b0, cnt_ff[dgrp_ff]} + (CNT_W+1)'(1);
   assign grant_more    = (fill_ff[dgrp_ff] != FILL_W'(1)) &&
                          (drain_cnt_inc != (CNT_W+1)'(MAX_INSIDE));
   assign head_step     = (head_ff[dgrp_ff] == QIDX_W'(QUEUE_DEPTH - 1)) ?
                          '0 : head_ff[dgrp_ff] + QIDX_W'(1);

   assign stat.out_free   = !ovalid_ff || out_ready;
   assign stat.drain_next = dec_drain;
   assign stat.grant_more = grant_more;

   always_comb begin
      mode_in   = mode_ff;
      grp_in    = grp_ff;
      id_in     = id_ff;
      dgrp_in   = dgrp_ff;
      cnt_in    = cnt_ff;
      fill_in   = fill_ff;
      head_in   = head_ff;
      ovalid_in = ovalid_ff && !out_ready;
      oev_in    = oev_ff;
      owho_in   = owho_ff;
      ogrp_in   = ogrp_ff;
      olast_in  = olast_ff;
      if (cmd.load) begin
         mode_in = in_mode;
         grp_in  = in_group;
         id_in   = ID_W'(in_id);
      end
      if (cmd.decide) begin
         dgrp_in = dec_dgrp;
         if (dec_push) fill_in[g] = fill_ff[g] + FILL_W'(1);
         if (dec_inc)  cnt_in[g]  = CNT_W'(own_cnt_inc);
         if (dec_dec)  cnt_in[g]  = cnt_ff[g] - CNT_W'(1);
         ovalid_in = 1'b1;
         oev_in    = dec_event;
         owho_in   = ID_FIELD_W'(id_ff);
         ogrp_in   = g;
         olast_in  = !dec_drain;
      end
      if (cmd.grant) begin
         head_in[dgrp_ff] = head_step;
         fill_in[dgrp_ff] = fill_ff[dgrp_ff] - FILL_W'(1);
         cnt_in[dgrp_ff]  = CNT_W'(drain_cnt_inc);
         ovalid_in = 1'b1;
         oev_in    = EV_GRANTED;
         owho_in   = ID_FIELD_W'(rd_data_ff);
         ogrp_in   = dgrp_ff;
         olast_in  = !grant_more;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '{default: '0};
         fill_ff   <= '{default: '0};
         head_ff   <= '{default: '0};
         ovalid_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         fill_ff   <= fill_in;
         head_ff   <= head_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      grp_ff   <= grp_in;
      id_ff    <= id_in;
      dgrp_ff  <= dgrp_in;
      oev_ff   <= oev_in;
      owho_ff  <= owho_in;
      ogrp_ff  <= ogrp_in;
      olast_ff <= olast_in;
   end

   // Queue storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.decide && dec_push) begin
         mem_ff[g][push_pos] <= id_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= mem_ff[dgrp_ff][head_ff[dgrp_ff]];
      end
   end

   assign out_valid = ovalid_ff;
   assign out_event = oev_ff;
   assign out_who   = owho_ff;
   assign out_group = ogrp_ff;
   assign out_last  = olast_ff;

   `TGSA_ASSERT_NOW(a_groups_exclusive, (cnt_ff[0] == '0) || (cnt_ff[1] == '0))
   `TGSA_ASSERT_IMP(a_grant_has_entry, cmd.grant,
                    (fill_ff[dgrp_ff] != '0) && (cnt_ff[dgrp_ff] != CNT_W'(MAX_INSIDE)))
   `TGSA_ASSERT_IMP(a_emit_into_free, cmd.decide || cmd.grant, stat.out_free)

endmodule

>>> design/tgsa_ctrl.sv
// Controller: sequences accept, decision and queue drain for one request.
module tgsa_ctrl import tgsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tgsa_stat_type stat,
   output tgsa_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_GRANT  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hold until the result register frees up
            if (stat.out_free) begin
               cmd.decide = 1'b1;
               state_in   = stat.drain_next ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_GRANT;
         end
         ST_GRANT: begin
            if (stat.out_free) begin
               cmd.grant = 1'b1;
               state_in  = stat.grant_more ? ST_READ : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/two_group_shared_access_arbiter.sv
// Two-group shared access arbiter: top level joining controller and datapath.
//
// Request channel (req_): one beat per enter request or exit notice;
// tuser carries mode and group, tdata the requester id.
// Response channel (rsp_): one beat per event; tuser carries the event code
// and the group, tdata the requester id, tlast marks the final beat that a
// request causes.
// A request is taken in the idle state and decided in the decide state, which
// waits while the result register is full; its first response beat is
// registered and shows in the cycle after the decision. A request that causes
// one beat uses only the idle and decide states. An exit or direct grant that
// drains a waiting queue adds a read state and a grant state per drained member.
// The next request is taken while the last response beat still waits.
// Reset clears both occupancy counts and both queues and puts the
// controller back to idle; queue storage itself is not cleared.
// When rsp_tready is low the pending beat holds and the controller waits
// before committing the next event, so no beat is lost or repeated.
module two_group_shared_access_arbiter import tgsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ID_FIELD_W-1:0] req_tdata,  // [7:0] requester_id
   input  logic [1:0]            req_tuser,  // [0] mode, [1] group
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ID_FIELD_W-1:0] rsp_tdata,  // [7:0] who
   output logic [EV_W:0]         rsp_tuser,  // [2:0] event_res, [3] which_group
   output logic                  rsp_tlast
);

   tgsa_cmd_type    cmd;
   tgsa_stat_type   stat;
   logic [EV_W-1:0] out_event;
   logic            out_group;

   tgsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   tgsa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_mode   (req_tuser[0]),
      .in_group  (req_tuser[1]),
      .in_id     (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_event (out_event),
      .out_who   (rsp_tdata),
      .out_group (out_group),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = {out_group, out_event};

endmodule

>>> sim/two_group_shared_access_arbiter_test.sv
// Testbench for the two-group shared access arbiter: directed request traffic.
module two_group_shared_access_arbiter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tgsa_pkg::*;

   localparam logic GROUP_FIRST  = 1'b0;
   localparam logic GROUP_SECOND = 1'b1;
   localparam int   QUIET_LIMIT  = 2000;
   localparam int   SETTLE_CYCLES = 20;
   localparam int   REPORT_LIMIT = 10;

   typedef struct packed {
      logic [EV_W-1:0]       ev;
      logic [ID_FIELD_W-1:0] who;
      logic                  grp;
      logic                  last;
   } arb_event_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ID_FIELD_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [ID_FIELD_W-1:0] rsp_tdata;
   logic [EV_W:0]         rsp_tuser;
   logic                  rsp_tlast;

   // predicted arbiter state
   int              inside_cnt [2] = '{0, 0};
   logic [ID_W-1:0] wait_ids [2][QUEUE_DEPTH];
   int              wait_head [2] = '{0, 0};
   int              wait_fill [2] = '{0, 0};

   arb_event_type expected_events[$];
   arb_event_type staged_event;
   logic          staged_valid = 1'b0;

   int   mismatch_count = 0;
   int   quiet_cycles   = 0;
   int   rsp_hold       = 0;
   logic rsp_beat_taken = 1'b0;
   bit   no_idle        = 1'b0;

   two_group_shared_access_arbiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // hold back the previous event so the final one of a request gets its last flag
   task automatic record_event(input logic [EV_W-1:0] ev, input logic [ID_W-1:0] id,
                               input logic grp);
      if (staged_valid) begin
         expected_events.push_back(staged_event);
      end
      staged_event = '{ev: ev, who: ID_FIELD_W'(id), grp: grp, last: 1'b0};
      staged_valid = 1'b1;
   endtask

   task automatic grant_waiting(input logic grp);
      while (wait_fill[grp] > 0 && inside_cnt[grp] < MAX_INSIDE) begin
         record_event(EV_GRANTED, wait_ids[grp][wait_head[grp]], grp);
         wait_head[grp] = (wait_head[grp] + 1) % QUEUE_DEPTH;
         wait_fill[grp]--;
         inside_cnt[grp]++;
      end
   endtask

   task automatic arbitrate_request(input logic mode, input logic grp,
                                    input logic [ID_FIELD_W-1:0] raw_id);
      logic            other;
      logic [ID_W-1:0] id;
      other        = ~grp;
      id           = raw_id[ID_W-1:0];
      staged_valid = 1'b0;
      if (mode == MODE_ENTER) begin
         if (inside_cnt[other] != 0 || wait_fill[other] != 0) begin
            if (wait_fill[grp] >= QUEUE_DEPTH) begin
               record_event(EV_QUEUE_FULL, id, grp);
            end else begin
               wait_ids[grp][(wait_head[grp] + wait_fill[grp]) % QUEUE_DEPTH] = id;
               wait_fill[grp]++;
               record_event(EV_QUEUED, id, grp);
            end
         end else if (inside_cnt[grp] >= MAX_INSIDE) begin
            record_event(EV_OCC_FULL, id, grp);
         end else begin
            inside_cnt[grp]++;
            record_event(EV_GRANTED, id, grp);
            grant_waiting(grp);
         end
      end else if (inside_cnt[grp] == 0) begin
         record_event(EV_EXIT_ERROR, id, grp);
      end else begin
         inside_cnt[grp]--;
         record_event(EV_RELEASED, id, grp);
         if (inside_cnt[grp] == 0) begin
            grant_waiting(other);
         end
      end
      staged_event.last = 1'b1;
      expected_events.push_back(staged_event);
   endtask

   task automatic send_request(input logic mode, input logic grp,
                               input logic [ID_FIELD_W-1:0] id);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = id;
      req_tuser  = {grp, mode};
      req_tvalid = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      arbitrate_request(mode, grp, id);
   endtask

   task automatic report_mismatch(input string what, input arb_event_type want,
                                  input arb_event_type seen);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display({"%0t: %s: expected ev=%0d who=%02h grp=%0d last=%0d, ",
                   "got ev=%0d who=%02h grp=%0d last=%0d"},
                  $realtime, what, want.ev, want.who, want.grp, want.last,
                  seen.ev, seen.who, seen.grp, seen.last);
      end
   endtask

   // response side: draw a stall after every beat
   always @(negedge clock) begin
      if (rsp_beat_taken) begin
         rsp_hold = no_idle ? 0 : $urandom_range(0, 7);
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end
      rsp_tready <= (rsp_hold == 0);
   end

   always @(posedge clock) begin : check_beat
      arb_event_type seen;
      arb_event_type want;
      rsp_beat_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen = '{ev: rsp_tuser[EV_W-1:0], who: rsp_tdata, grp: rsp_tuser[EV_W],
                  last: rsp_tlast};
         if (expected_events.size() == 0) begin
            report_mismatch("beat with nothing pending", '0, seen);
         end else begin
            want = expected_events.pop_front();
            if (seen !== want) begin
               report_mismatch("event mismatch", want, seen);
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_basic_exchange;
      send_request(MODE_ENTER, GROUP_FIRST,  8'h00);
      send_request(MODE_ENTER, GROUP_FIRST,  8'hFF);
      send_request(MODE_ENTER, GROUP_SECOND, 8'h55);
      send_request(MODE_ENTER, GROUP_SECOND, 8'hAA);
      // other group waiting: queue even though own group is inside
      send_request(MODE_ENTER, GROUP_FIRST,  8'h0F);
      send_request(MODE_EXIT,  GROUP_SECOND, 8'h55);
      send_request(MODE_EXIT,  GROUP_FIRST,  8'h00);
      send_request(MODE_EXIT,  GROUP_FIRST,  8'hFF);
      send_request(MODE_ENTER, GROUP_SECOND, 8'hF0);
      send_request(MODE_EXIT,  GROUP_SECOND, 8'h55);
      send_request(MODE_EXIT,  GROUP_SECOND, 8'hAA);
      send_request(MODE_EXIT,  GROUP_FIRST,  8'h0F);
      send_request(MODE_EXIT,  GROUP_SECOND, 8'hF0);
      send_request(MODE_EXIT,  GROUP_SECOND, 8'hF0);
      send_request(MODE_EXIT,  GROUP_FIRST,  8'h3C);
      send_request(MODE_ENTER, GROUP_SECOND, 8'h01);
      send_request(MODE_EXIT,  GROUP_SECOND, 8'h01);
   endtask

   // leaves the second group inside with a full queue's worth of members
   task automatic test_queue_overflow;
      send_request(MODE_ENTER, GROUP_FIRST, 8'h80);
      for (int i = 0; i <= QUEUE_DEPTH; i++) begin
         send_request(MODE_ENTER, GROUP_SECOND, ID_FIELD_W'(i * 15));
      end
      // one exit releases the whole second queue
      send_request(MODE_EXIT, GROUP_FIRST, 8'h80);
   endtask

   task automatic test_occupancy_limit;
      no_idle = 1'b1;
      while (inside_cnt[GROUP_SECOND] < MAX_INSIDE) begin
         send_request(MODE_ENTER, GROUP_SECOND, ID_FIELD_W'($urandom_range(0, 255)));
      end
      send_request(MODE_ENTER, GROUP_SECOND, 8'hC3);
      no_idle = 1'b0;
      send_request(MODE_ENTER, GROUP_FIRST,  8'h42);
      send_request(MODE_ENTER, GROUP_SECOND, 8'h24);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_exchange();
      test_queue_overflow();
      test_occupancy_limit();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/tgsa_pkg.sv
design/tgsa_dp.sv
design/tgsa_ctrl.sv
design/two_group_shared_access_arbiter.sv
sim/two_group_shared_access_arbiter_test.sv
